/* rtl/hbrq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrq_pkg
// Shared types and constants of the half-plane bounding rectangle query block.
// ----------------------------------------------------------------------------
package hbrq_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int FRAC_BITS   = 16;
    localparam int COEF_W      = 16;
    localparam int COORD_W     = 34;
    localparam int AREA_W      = 51;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DIVN_W      = COEF_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIVN_W + 1);
    localparam int HALF_W      = COORD_W / 2;
    localparam int PROD_W      = 2 * COORD_W;

    typedef enum logic [1:0] {
        KIND_LEFT,
        KIND_RIGHT,
        KIND_LOWER,
        KIND_UPPER
    } t_kind;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_DEGEN    = 3'd2,
        ST_NONE     = 3'd3,
        ST_FOUND    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_SPAN,
        S_MUL_LO,
        S_MUL_HI,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                      valid;
        t_kind                     kind;
        logic signed [COORD_W-1:0] value;
    } t_cell;

endpackage

/* rtl/hbrq_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrq_req_if
// Request channel: half-plane insert or query point.
// ----------------------------------------------------------------------------
interface hbrq_req_if import hbrq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [COEF_W-1:0]  coef_a;
    logic signed [COEF_W-1:0]  coef_b;
    logic signed [COEF_W-1:0]  coef_c;
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;

    modport source (output valid, req_type, coef_a, coef_b, coef_c, query_x, query_y,
                    input ready);
    modport sink   (input valid, req_type, coef_a, coef_b, coef_c, query_x, query_y,
                    output ready);
endinterface

/* rtl/hbrq_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrq_rsp_if
// Response channel: status and rectangle area.
// ----------------------------------------------------------------------------
interface hbrq_rsp_if import hbrq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [AREA_W-1:0] area;

    modport source (output valid, status, area, input ready);
    modport sink   (input valid, status, area, output ready);
endinterface

/* rtl/hbrq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrq_cell
// One stored bound; takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
module hbrq_cell import hbrq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_cell i_prev,
    output t_cell o_cell
);
    logic                      r_valid;
    t_kind                     r_kind;
    logic signed [COORD_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_kind  <= i_prev.kind;
            r_value <= i_prev.value;
        end
    end

    assign o_cell = '{valid: r_valid, kind: r_kind, value: r_value};
endmodule

/* rtl/hbrq_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrq_div
// Restoring divider, one quotient bit per cycle: -num/den in fixed point.
// ----------------------------------------------------------------------------
module hbrq_div import hbrq_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [COEF_W-1:0]  i_num,
    input  logic signed [COEF_W-1:0]  i_den,
    output logic                      o_done,
    output logic signed [COORD_W-1:0] o_quo
);
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COEF_W-1:0]    r_rem;
    logic [DIVN_W-1:0]    r_quo;
    logic [COEF_W-1:0]    r_den;
    logic                 r_neg;

    logic [COEF_W-1:0]    w_num_abs;
    logic [COEF_W-1:0]    w_den_abs;
    logic [COEF_W:0]      w_shl;
    logic [COEF_W+1:0]    w_diff;
    logic                 w_ge;
    logic [COORD_W-1:0]   w_mag;

    assign w_num_abs = i_num[COEF_W-1] ? COEF_W'(-i_num) : i_num;
    assign w_den_abs = i_den[COEF_W-1] ? COEF_W'(-i_den) : i_den;
    assign w_shl     = {r_rem, r_quo[DIVN_W-1]};
    assign w_diff    = {1'b0, w_shl} - {2'b00, r_den};
    assign w_ge      = !w_diff[COEF_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIVN_W);
            r_rem <= '0;
            r_quo <= {w_num_abs, {FRAC_BITS{1'b0}}};
            r_den <= w_den_abs;
            // result is negative when num and den agree in sign
            r_neg <= (!i_num[COEF_W-1] && i_num != '0) != i_den[COEF_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            r_rem <= w_ge ? w_diff[COEF_W-1:0] : w_shl[COEF_W-1:0];
            r_quo <= {r_quo[DIVN_W-2:0], w_ge};
        end
    end

    assign w_mag  = COORD_W'(r_quo);
    assign o_quo  = r_neg ? -$signed(w_mag) : $signed(w_mag);
    assign o_done = r_done;
endmodule

/* rtl/halfplane_bounding_rectangle_query_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfplane_bounding_rectangle_query_top
// Stores axis-parallel half-plane bounds and reports the bounding rectangle
// around a query point.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. An insert runs through the 32-step
// divider; a rejected insert skips the divider. A query rotates the ring of
// TABLE_DEPTH cells that holds the bounds once, one entry past the comparator
// per cycle, then span, two multiply steps if all four bounds are found, and
// output. A finished result waits in the output register until it is taken.
// ----------------------------------------------------------------------------
module halfplane_bounding_rectangle_query_top import hbrq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbrq_req_if.sink    i_req,
    hbrq_rsp_if.source  o_rsp
);
    t_state r_state, n_state;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_scan_cnt;
    logic signed [COORD_W-1:0] r_qx, r_qy;
    t_kind                     r_kind;
    logic signed [COORD_W-1:0] r_best [4];
    logic [3:0]                r_have;
    logic [COORD_W-1:0]        r_w, r_h;
    logic [PROD_W-1:0]         r_prod;
    t_status                   r_res_status;
    logic                      r_out_valid;
    logic [2:0]                r_out_status;
    logic [AREA_W-1:0]         r_out_area;

    logic                      w_accept;
    logic                      w_div_start;
    logic                      w_div_done;
    logic signed [COORD_W-1:0] w_div_quo;
    logic                      w_shift;
    t_cell                     w_chain_in;
    t_cell                     w_chain [TABLE_DEPTH];
    t_cell                     w_head;
    logic signed [COORD_W-1:0] w_p;
    logic signed [COORD_W-1:0] w_cur;
    logic                      w_below;
    logic                      w_hit;
    logic                      w_out_free;
    logic [PROD_W-1:0]         w_shifted;
    logic [AREA_W-1:0]         w_area;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_div_start = w_accept && !i_req.req_type
                         && !(i_req.coef_a == '0 && i_req.coef_b == '0)
                         && r_count != CNT_W'(TABLE_DEPTH);

    hbrq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (i_req.coef_c),
        .i_den   (i_req.coef_a != '0 ? i_req.coef_a : i_req.coef_b),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // ring of cells: an insert shifts a new entry in at the front, a scan
    // rotates the last entry back to the front
    assign w_head     = w_chain[TABLE_DEPTH-1];
    assign w_shift    = (r_state == S_SCAN) || w_div_done;
    assign w_chain_in = (r_state == S_SCAN) ? w_head
                        : '{valid: 1'b1, kind: r_kind, value: w_div_quo};

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            hbrq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_prev  (w_chain_in),
                .o_cell  (w_chain[g])
            );
        end else begin : g_rest
            hbrq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_prev  (w_chain[g-1]),
                .o_cell  (w_chain[g])
            );
        end
    end

    assign w_p     = (w_head.kind == KIND_LEFT || w_head.kind == KIND_RIGHT) ? r_qx : r_qy;
    assign w_below = (w_head.kind == KIND_LEFT || w_head.kind == KIND_LOWER);
    assign w_cur   = r_best[w_head.kind];
    assign w_hit   = w_head.valid && (w_below
                     ? (w_head.value < w_p && (!r_have[w_head.kind] || w_head.value > w_cur))
                     : (w_head.value > w_p && (!r_have[w_head.kind] || w_head.value < w_cur)));

    assign w_shifted = r_prod >> FRAC_BITS;
    assign w_area    = (w_shifted > PROD_W'({AREA_W{1'b1}})) ? {AREA_W{1'b1}}
                       : w_shifted[AREA_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type) begin
                        n_state = S_SCAN;
                    end else if (w_div_start) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) n_state = S_DONE;
            end
            S_SCAN: begin
                if (r_scan_cnt == CNT_W'(TABLE_DEPTH - 1)) n_state = S_SPAN;
            end
            S_SPAN: begin
                n_state = (r_have == 4'b1111) ? S_MUL_LO : S_DONE;
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_div_done) r_count <= r_count + CNT_W'(1);
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_qx       <= i_req.query_x;
                r_qy       <= i_req.query_y;
                r_scan_cnt <= '0;
                r_have     <= '0;
                r_prod     <= '0;
                if (i_req.coef_a != '0) begin
                    r_kind <= i_req.coef_a[COEF_W-1] ? KIND_LEFT : KIND_RIGHT;
                end else begin
                    r_kind <= i_req.coef_b[COEF_W-1] ? KIND_LOWER : KIND_UPPER;
                end
                if (i_req.coef_a == '0 && i_req.coef_b == '0) begin
                    r_res_status <= ST_DEGEN;
                end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    r_res_status <= ST_FULL;
                end else begin
                    r_res_status <= ST_INSERTED;
                end
            end
            S_SCAN: begin
                r_scan_cnt <= r_scan_cnt + CNT_W'(1);
                if (w_hit) begin
                    r_best[w_head.kind] <= w_head.value;
                    r_have[w_head.kind] <= 1'b1;
                end
            end
            S_SPAN: begin
                r_w          <= COORD_W'(r_best[KIND_RIGHT] - r_best[KIND_LEFT]);
                r_h          <= COORD_W'(r_best[KIND_UPPER] - r_best[KIND_LOWER]);
                r_res_status <= (r_have == 4'b1111) ? ST_FOUND : ST_NONE;
            end
            S_MUL_LO: begin
                r_prod <= PROD_W'(r_w[HALF_W-1:0] * r_h);
            end
            S_MUL_HI: begin
                r_prod <= r_prod + (PROD_W'(r_w[COORD_W-1:HALF_W] * r_h) << HALF_W);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_area   <= (r_res_status == ST_FOUND) ? w_area : '0;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.area   = r_out_area;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("bound count above table depth");

    a_area_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != ST_FOUND |-> o_rsp.area == '0)
        else $error("nonzero area without rectangle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("idle right after accepting a transaction");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside insert");
endmodule
